@@ rtl/core/intrusion_and_smoke_alarm_core_defines.svh @@
// Assertion macros for the intrusion and smoke alarm core
`ifndef INTRUSION_AND_SMOKE_ALARM_CORE_DEFINES_SVH
`define INTRUSION_AND_SMOKE_ALARM_CORE_DEFINES_SVH

// check a property on every clock edge outside reset
`define ISA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define ISA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/isa_pkg.sv @@
// Shared types and constants for the intrusion and smoke alarm core
package isa_pkg;

	localparam int SMOKE_W = 10;
	localparam int PCT_W = 7;
	localparam int MODE_W = 2;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int DEBOUNCE_DEFAULT = 3;

	localparam logic [MODE_W-1:0] MODE_INACTIVE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ARMED = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRIGGERED = 2'd2;

	localparam logic [SMOKE_W-1:0] SMOKE_MAX = 10'd1023;
	localparam logic [SMOKE_W-1:0] THRESHOLD_RESET = 10'd400;
	localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

	localparam logic REG_THRESHOLD = 1'b0;

	typedef logic [MODE_W-1:0] mode_t;

	typedef struct packed {
		logic arm_access;
		logic arm_fire;
		logic pir_one;
		logic pir_two;
		logic fire_test;
		logic access_test;
		logic smoke_valid;
		logic [SMOKE_W-1:0] smoke_sample;
	} tick_t;

	typedef struct packed {
		mode_t access_state;
		mode_t fire_state;
		logic [SMOKE_W-1:0] smoke_level;
		logic [PCT_W-1:0] smoke_pct;
		logic pir_one_level;
		logic pir_two_level;
	} status_t;

endpackage

@@ rtl/core/isa_pct.sv @@
// Smoke sample to percent conversion: sample * 100 / 1023, truncated
module isa_pct (
	input  logic [isa_pkg::SMOKE_W-1:0] sample,
	output logic [isa_pkg::PCT_W-1:0]   percent
);
	import isa_pkg::*;

	localparam int PROD_W = SMOKE_W + PCT_W;

	logic [PROD_W-1:0]  prod;
	logic [PCT_W-1:0]   quot;
	logic [SMOKE_W:0]   rem;

	// divide by 1024 - 1: estimate by shift, then one correction step
	assign prod = PROD_W'(sample) * PROD_W'(PCT_SCALE);
	assign quot = prod[PROD_W-1:SMOKE_W];
	assign rem = (SMOKE_W+1)'(prod[SMOKE_W-1:0]) + (SMOKE_W+1)'(quot);

	always_comb begin
		if (rem >= (SMOKE_W+1)'(SMOKE_MAX)) begin
			percent = quot + PCT_W'(1);
		end else begin
			percent = quot;
		end
	end

endmodule

@@ rtl/core/isa_cfg.sv @@
// APB register block holding the smoke threshold
module isa_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [isa_pkg::APB_AW-1:0] paddr,
	input  logic [isa_pkg::APB_DW-1:0] pwdata,
	output logic [isa_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [isa_pkg::SMOKE_W-1:0] threshold
);
	import isa_pkg::*;

	logic                wr_en;
	logic                reg_idx;
	logic [SMOKE_W-1:0]  wr_val;
	logic [SMOKE_W-1:0]  threshold_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[APB_AW-1];
	assign wr_en = psel && penable && pwrite && pready;

	// saturate writes beyond the sample range
	assign wr_val = (|pwdata[APB_DW-1:SMOKE_W]) ? SMOKE_MAX : pwdata[SMOKE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (wr_en && reg_idx == REG_THRESHOLD) begin
			threshold_q <= wr_val;
		end
	end

	assign prdata = (reg_idx == REG_THRESHOLD) ? APB_DW'(threshold_q) : '0;
	assign threshold = threshold_q;

endmodule

@@ rtl/core/isa_ctrl.sv @@
// Alarm state update: arming, motion edges, smoke debounce and test switches
`include "intrusion_and_smoke_alarm_core_defines.svh"

module isa_ctrl #(
	parameter int DEBOUNCE_COUNT = isa_pkg::DEBOUNCE_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  isa_pkg::tick_t              tick,
	input  logic [isa_pkg::SMOKE_W-1:0] threshold,
	output isa_pkg::status_t            status
);
	import isa_pkg::*;

	localparam int RUN_W = $clog2(DEBOUNCE_COUNT + 1);
	localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(DEBOUNCE_COUNT);

	mode_t               access_mode_q;
	mode_t               fire_mode_q;
	logic                prev_pir_one_q;
	logic                prev_pir_two_q;
	logic [RUN_W-1:0]    smoke_run_q;
	logic [SMOKE_W-1:0]  held_smoke_q;
	logic [PCT_W-1:0]    held_pct_q;

	mode_t               access_nxt;
	mode_t               fire_nxt;
	logic [RUN_W-1:0]    run_nxt;
	logic                motion;
	logic [PCT_W-1:0]    pct;

	isa_pct u_pct (
		.sample  (tick.smoke_sample),
		.percent (pct)
	);

	assign motion = (tick.pir_one && !prev_pir_one_q) || (tick.pir_two && !prev_pir_two_q);

	always_comb begin
		access_nxt = access_mode_q;
		fire_nxt = fire_mode_q;
		run_nxt = smoke_run_q;

		if (!tick.arm_access) begin
			access_nxt = MODE_INACTIVE;
		end else if (access_mode_q == MODE_INACTIVE) begin
			access_nxt = MODE_ARMED;
		end

		if (!tick.arm_fire) begin
			fire_nxt = MODE_INACTIVE;
			run_nxt = '0;
		end else if (fire_mode_q == MODE_INACTIVE) begin
			fire_nxt = MODE_ARMED;
			run_nxt = '0;
		end

		if (access_nxt == MODE_ARMED && motion) begin
			access_nxt = MODE_TRIGGERED;
		end

		if (tick.smoke_valid && fire_nxt == MODE_ARMED) begin
			if (tick.smoke_sample > threshold) begin
				if (run_nxt < RUN_MAX) begin
					run_nxt = run_nxt + RUN_W'(1);
				end
				if (run_nxt >= RUN_MAX) begin
					fire_nxt = MODE_TRIGGERED;
				end
			end else begin
				run_nxt = '0;
			end
		end

		if (tick.fire_test && fire_nxt == MODE_ARMED) begin
			fire_nxt = MODE_TRIGGERED;
		end
		if (tick.access_test && access_nxt == MODE_ARMED) begin
			access_nxt = MODE_TRIGGERED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_mode_q <= MODE_INACTIVE;
			fire_mode_q <= MODE_INACTIVE;
			prev_pir_one_q <= 1'b0;
			prev_pir_two_q <= 1'b0;
			smoke_run_q <= '0;
			held_smoke_q <= '0;
			held_pct_q <= '0;
		end else if (adv) begin
			access_mode_q <= access_nxt;
			fire_mode_q <= fire_nxt;
			prev_pir_one_q <= tick.pir_one;
			prev_pir_two_q <= tick.pir_two;
			smoke_run_q <= run_nxt;
			if (tick.smoke_valid) begin
				held_smoke_q <= tick.smoke_sample;
				held_pct_q <= pct;
			end
		end
	end

	assign status.access_state = access_mode_q;
	assign status.fire_state = fire_mode_q;
	assign status.smoke_level = held_smoke_q;
	assign status.smoke_pct = held_pct_q;
	assign status.pir_one_level = prev_pir_one_q;
	assign status.pir_two_level = prev_pir_two_q;

	`ISA_ASSERT(a_run_bounded, smoke_run_q <= RUN_MAX, "smoke run beyond debounce count")
	`ISA_ASSERT_NEXT(a_access_disarm, adv && !tick.arm_access,
		access_mode_q == MODE_INACTIVE, "access alarm not cleared on disarm")
	`ISA_ASSERT_NEXT(a_fire_disarm, adv && !tick.arm_fire,
		fire_mode_q == MODE_INACTIVE && smoke_run_q == '0, "fire alarm not cleared on disarm")

endmodule

@@ rtl/core/intrusion_and_smoke_alarm_core.sv @@
// Top level of the intrusion and smoke alarm core
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------
//   tick     | tick_valid / tick_stall    | arm, PIR, test switch and smoke fields
//   result   | result_valid / result_stall| alarm states, drives, smoke level and %
//   config   | APB psel/penable/pwrite    | smoke alarm threshold at byte address 0
//
// One transaction per cycle sustained while results are not stalled; an accepted tick
// enters the input register, then the alarm state register once the result advances.
// The alarm state registers double as the result register, so a result holds
// while stalled and the next tick waits in the input register.
// A stalled result backs up through the input register to tick_stall at once.
// Reset clears both alarms to inactive and the held smoke data; threshold is 400.
module intrusion_and_smoke_alarm_core #(
	parameter int DEBOUNCE_COUNT = isa_pkg::DEBOUNCE_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        tick_valid,
	output logic                        tick_stall,
	input  logic                        arm_access,
	input  logic                        arm_fire,
	input  logic                        pir_one,
	input  logic                        pir_two,
	input  logic                        fire_test,
	input  logic                        access_test,
	input  logic                        smoke_valid,
	input  logic [isa_pkg::SMOKE_W-1:0] smoke_sample,

	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [isa_pkg::MODE_W-1:0]  access_state,
	output logic [isa_pkg::MODE_W-1:0]  fire_state,
	output logic                        buzzer_on,
	output logic                        fire_led_on,
	output logic [isa_pkg::SMOKE_W-1:0] smoke_level,
	output logic [isa_pkg::PCT_W-1:0]   smoke_pct,
	output logic                        pir_one_level,
	output logic                        pir_two_level,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [isa_pkg::APB_AW-1:0]  paddr,
	input  logic [isa_pkg::APB_DW-1:0]  pwdata,
	output logic [isa_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import isa_pkg::*;

	tick_t               tick_s1;
	logic                valid_s1;
	logic                result_valid_q;
	logic                adv;
	logic                accept;
	logic [SMOKE_W-1:0]  threshold;
	status_t             status;

	assign adv = valid_s1 && (!result_valid_q || !result_stall);
	assign tick_stall = valid_s1 && !adv;
	assign accept = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1.arm_access <= arm_access;
			tick_s1.arm_fire <= arm_fire;
			tick_s1.pir_one <= pir_one;
			tick_s1.pir_two <= pir_two;
			tick_s1.fire_test <= fire_test;
			tick_s1.access_test <= access_test;
			tick_s1.smoke_valid <= smoke_valid;
			tick_s1.smoke_sample <= smoke_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	isa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	isa_ctrl #(
		.DEBOUNCE_COUNT (DEBOUNCE_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tick      (tick_s1),
		.threshold (threshold),
		.status    (status)
	);

	assign result_valid = result_valid_q;
	assign access_state = status.access_state;
	assign fire_state = status.fire_state;
	assign buzzer_on = (status.access_state == MODE_TRIGGERED);
	assign fire_led_on = (status.fire_state == MODE_TRIGGERED);
	assign smoke_level = status.smoke_level;
	assign smoke_pct = status.smoke_pct;
	assign pir_one_level = status.pir_one_level;
	assign pir_two_level = status.pir_two_level;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the intrusion and smoke alarm core
module testbench;

	import isa_pkg::*;

	localparam int RUN_DEBOUNCE = DEBOUNCE_DEFAULT;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_TICKS = 185;
	localparam int PHASES = 5;
	localparam int MAX_REPORTS = 40;
	localparam logic [APB_AW-1:0] THRESHOLD_ADDR = APB_AW'(4 * REG_THRESHOLD);
	localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'(4);

	typedef struct packed {
		mode_t access_state;
		mode_t fire_state;
		logic buzzer_on;
		logic fire_led_on;
		logic [SMOKE_W-1:0] smoke_level;
		logic [PCT_W-1:0] smoke_pct;
		logic pir_one_level;
		logic pir_two_level;
	} alarm_status_t;

	class alarm_status_board;
		mode_t access_mode;
		mode_t fire_mode;
		logic last_pir_one;
		logic last_pir_two;
		int unsigned smoke_run;
		logic [SMOKE_W-1:0] held_smoke;
		logic [PCT_W-1:0] held_percent;
		logic [SMOKE_W-1:0] threshold;
		alarm_status_t status_due[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned access_trips;
		int unsigned fire_trips;

		function new();
			access_mode = MODE_INACTIVE;
			fire_mode = MODE_INACTIVE;
			last_pir_one = 1'b0;
			last_pir_two = 1'b0;
			smoke_run = 0;
			held_smoke = '0;
			held_percent = '0;
			threshold = THRESHOLD_RESET;
			errors = 0;
			checked = 0;
			access_trips = 0;
			fire_trips = 0;
		endfunction

		function int unsigned pending();
			return status_due.size();
		endfunction

		function void write_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
			if (addr == THRESHOLD_ADDR)
				threshold = (data > APB_DW'(SMOKE_MAX)) ? SMOKE_MAX : data[SMOKE_W-1:0];
		endfunction

		function void note_tick(tick_t t);
			alarm_status_t s;
			mode_t access_was;
			mode_t fire_was;
			access_was = access_mode;
			fire_was = fire_mode;
			if (t.arm_access) begin
				if (access_mode == MODE_INACTIVE)
					access_mode = MODE_ARMED;
			end else begin
				access_mode = MODE_INACTIVE;
			end
			if (t.arm_fire) begin
				if (fire_mode == MODE_INACTIVE) begin
					fire_mode = MODE_ARMED;
					smoke_run = 0;
				end
			end else begin
				fire_mode = MODE_INACTIVE;
				smoke_run = 0;
			end
			if (access_mode == MODE_ARMED &&
			    ((t.pir_one && !last_pir_one) || (t.pir_two && !last_pir_two)))
				access_mode = MODE_TRIGGERED;
			last_pir_one = t.pir_one;
			last_pir_two = t.pir_two;
			if (t.smoke_valid) begin
				held_smoke = t.smoke_sample;
				held_percent = PCT_W'(int'(t.smoke_sample) * int'(PCT_SCALE) / int'(SMOKE_MAX));
				if (fire_mode == MODE_ARMED) begin
					if (t.smoke_sample > threshold) begin
						if (smoke_run < RUN_DEBOUNCE)
							smoke_run++;
						if (smoke_run >= RUN_DEBOUNCE)
							fire_mode = MODE_TRIGGERED;
					end else begin
						smoke_run = 0;
					end
				end
			end
			if (t.fire_test && fire_mode == MODE_ARMED)
				fire_mode = MODE_TRIGGERED;
			if (t.access_test && access_mode == MODE_ARMED)
				access_mode = MODE_TRIGGERED;
			if (access_was != MODE_TRIGGERED && access_mode == MODE_TRIGGERED)
				access_trips++;
			if (fire_was != MODE_TRIGGERED && fire_mode == MODE_TRIGGERED)
				fire_trips++;
			s.access_state = access_mode;
			s.fire_state = fire_mode;
			s.buzzer_on = (access_mode == MODE_TRIGGERED);
			s.fire_led_on = (fire_mode == MODE_TRIGGERED);
			s.smoke_level = held_smoke;
			s.smoke_pct = held_percent;
			s.pir_one_level = t.pir_one;
			s.pir_two_level = t.pir_two;
			status_due.push_back(s);
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_status(alarm_status_t got);
			alarm_status_t want;
			if (status_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected status result, expected none, got %h", $time, got);
				return;
			end
			want = status_due.pop_front();
			checked++;
			report("access_state", 32'(want.access_state), 32'(got.access_state));
			report("fire_state", 32'(want.fire_state), 32'(got.fire_state));
			report("buzzer_on", 32'(want.buzzer_on), 32'(got.buzzer_on));
			report("fire_led_on", 32'(want.fire_led_on), 32'(got.fire_led_on));
			report("smoke_level", 32'(want.smoke_level), 32'(got.smoke_level));
			report("smoke_pct", 32'(want.smoke_pct), 32'(got.smoke_pct));
			report("pir_one_level", 32'(want.pir_one_level), 32'(got.pir_one_level));
			report("pir_two_level", 32'(want.pir_two_level), 32'(got.pir_two_level));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic tick_valid;
	logic tick_stall;
	logic arm_access;
	logic arm_fire;
	logic pir_one;
	logic pir_two;
	logic fire_test;
	logic access_test;
	logic smoke_valid;
	logic [SMOKE_W-1:0] smoke_sample;
	logic result_valid;
	logic result_stall;
	logic [MODE_W-1:0] access_state;
	logic [MODE_W-1:0] fire_state;
	logic buzzer_on;
	logic fire_led_on;
	logic [SMOKE_W-1:0] smoke_level;
	logic [PCT_W-1:0] smoke_pct;
	logic pir_one_level;
	logic pir_two_level;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	alarm_status_board board = new();

	int unsigned ticks_sent;
	int unsigned idle_cycles;
	int unsigned cur_threshold;
	int unsigned settings_used;
	bit tx_quiet;
	bit rx_quiet;
	bit hold_off_pending;
	logic lvl_arm_access;
	logic lvl_arm_fire;
	logic lvl_pir_one;
	logic lvl_pir_two;

	intrusion_and_smoke_alarm_core #(
		.DEBOUNCE_COUNT(RUN_DEBOUNCE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.arm_access(arm_access),
		.arm_fire(arm_fire),
		.pir_one(pir_one),
		.pir_two(pir_two),
		.fire_test(fire_test),
		.access_test(access_test),
		.smoke_valid(smoke_valid),
		.smoke_sample(smoke_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.access_state(access_state),
		.fire_state(fire_state),
		.buzzer_on(buzzer_on),
		.fire_led_on(fire_led_on),
		.smoke_level(smoke_level),
		.smoke_pct(smoke_pct),
		.pir_one_level(pir_one_level),
		.pir_two_level(pir_two_level),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic tick_t make_tick(logic aa, logic af, logic p1, logic p2, logic ft,
		logic at, logic sv, int unsigned sample);
		tick_t t;
		t.arm_access = aa;
		t.arm_fire = af;
		t.pir_one = p1;
		t.pir_two = p2;
		t.fire_test = ft;
		t.access_test = at;
		t.smoke_valid = sv;
		t.smoke_sample = SMOKE_W'(sample);
		return t;
	endfunction

	function automatic int unsigned pick_sample();
		int unsigned r;
		int v;
		r = $urandom_range(0, 11);
		if (r < 4) begin
			v = int'(cur_threshold) + int'($urandom_range(0, 4)) - 2;
			if (v < 0)
				v = 0;
			if (v > int'(SMOKE_MAX))
				v = int'(SMOKE_MAX);
			return v;
		end else if (r < 7) begin
			if (cur_threshold >= SMOKE_MAX)
				return SMOKE_MAX;
			return $urandom_range(cur_threshold + 1, SMOKE_MAX);
		end else if (r < 9) begin
			return $urandom_range(0, cur_threshold);
		end else if (r < 11) begin
			return $urandom_range(0, SMOKE_MAX);
		end
		return ($urandom_range(0, 1) != 0) ? SMOKE_MAX : 0;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		if ($urandom_range(0, 11) == 0) begin
			t = $bits(tick_t)'($urandom);
			return t;
		end
		if (lvl_arm_access)
			lvl_arm_access = ($urandom_range(0, 29) != 0);
		else
			lvl_arm_access = ($urandom_range(0, 2) == 0);
		if (lvl_arm_fire)
			lvl_arm_fire = ($urandom_range(0, 29) != 0);
		else
			lvl_arm_fire = ($urandom_range(0, 2) == 0);
		if ($urandom_range(0, 5) == 0)
			lvl_pir_one = !lvl_pir_one;
		if ($urandom_range(0, 5) == 0)
			lvl_pir_two = !lvl_pir_two;
		t = make_tick(lvl_arm_access, lvl_arm_fire, lvl_pir_one, lvl_pir_two,
			$urandom_range(0, 24) == 0, $urandom_range(0, 24) == 0,
			$urandom_range(0, 2) != 0, pick_sample());
		return t;
	endfunction

	task automatic send_tick(tick_t t);
		int unsigned gap;
		gap = tx_quiet ? 0 : pick_idle();
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid <= 1'b1;
		arm_access <= t.arm_access;
		arm_fire <= t.arm_fire;
		pir_one <= t.pir_one;
		pir_two <= t.pir_two;
		fire_test <= t.fire_test;
		access_test <= t.access_test;
		smoke_valid <= t.smoke_valid;
		smoke_sample <= t.smoke_sample;
		do
			@(posedge clk);
		while (!(tick_valid && !tick_stall));
		board.note_tick(t);
		ticks_sent++;
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(logic write, logic [APB_AW-1:0] addr,
		logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		if (write)
			board.write_register(addr, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_threshold(logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] rdata;
		apb_access(1'b1, THRESHOLD_ADDR, value, rdata);
		apb_access(1'b1, UNMAPPED_ADDR, APB_DW'($urandom), rdata);
		apb_access(1'b0, THRESHOLD_ADDR, '0, rdata);
		board.report("threshold readback", 32'(board.threshold), rdata);
		cur_threshold = board.threshold;
		settings_used++;
	endtask

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			board.check_status('{access_state, fire_state, buzzer_on, fire_led_on,
				smoke_level, smoke_pct, pir_one_level, pir_two_level});

	always @(posedge clk) begin
		if (!arst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("intrusion_and_smoke_alarm_core test failed");
			$finish;
		end
	end

	initial begin : result_side
		int unsigned run;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (rx_quiet) begin
				result_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 9) < 3) begin
				run = pick_idle();
				result_stall <= 1'b1;
				repeat (run == 0 ? 1 : run) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [APB_DW-1:0] phase_value[PHASES];
		tick_t directed[$];
		idle_cycles = 0;
		ticks_sent = 0;
		settings_used = 0;
		cur_threshold = THRESHOLD_RESET;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_off_pending = 1'b0;
		lvl_arm_access = 1'b1;
		lvl_arm_fire = 1'b1;
		lvl_pir_one = 1'b0;
		lvl_pir_two = 1'b0;
		arst_n = 1'b0;
		tick_valid = 1'b0;
		arm_access = 1'b0;
		arm_fire = 1'b0;
		pir_one = 1'b0;
		pir_two = 1'b0;
		fire_test = 1'b0;
		access_test = 1'b0;
		smoke_valid = 1'b0;
		smoke_sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_tick(0, 0, 0, 0, 0, 0, 1, 0));
		directed.push_back(make_tick(0, 0, 1, 0, 1, 1, 1, 1023));
		directed.push_back(make_tick(1, 1, 1, 0, 0, 0, 1, 401));
		directed.push_back(make_tick(1, 1, 0, 0, 0, 0, 1, 401));
		directed.push_back(make_tick(1, 1, 0, 0, 0, 0, 1, 400));
		directed.push_back(make_tick(1, 1, 0, 0, 0, 0, 1, 1023));
		directed.push_back(make_tick(1, 1, 0, 0, 0, 0, 0, 10'h2AA));
		directed.push_back(make_tick(1, 1, 0, 0, 0, 0, 1, 1023));
		directed.push_back(make_tick(1, 1, 0, 1, 0, 0, 1, 1023));
		directed.push_back(make_tick(1, 1, 0, 1, 1, 1, 1, 1023));
		directed.push_back(make_tick(1, 1, 1, 0, 0, 0, 1, 1023));
		directed.push_back(make_tick(0, 0, 1, 0, 0, 0, 0, 10'h155));
		directed.push_back(make_tick(1, 1, 1, 0, 1, 0, 0, 0));
		directed.push_back(make_tick(1, 1, 1, 0, 0, 1, 0, 0));
		directed.push_back(make_tick(1, 0, 1, 1, 0, 0, 1, 500));
		directed.push_back(make_tick(1, 1, 1, 1, 0, 0, 1, 500));
		directed.push_back(make_tick(1, 0, 1, 1, 0, 0, 1, 500));
		directed.push_back(make_tick(1, 1, 1, 1, 0, 0, 1, 500));
		directed.push_back(make_tick(1, 1, 1, 1, 0, 0, 1, 500));
		directed.push_back(make_tick(1, 0, 1, 1, 0, 0, 1, 500));
		directed.push_back(make_tick(1, 1, 1, 1, 0, 0, 1, 500));
		directed.push_back(make_tick(0, 0, 0, 0, 0, 0, 1, 10'h155));
		directed.push_back(make_tick(1, 1, 1, 1, 1, 1, 1, 1023));
		foreach (directed[i])
			send_tick(directed[i]);
		drain();

		phase_value[0] = $urandom_range(1, SMOKE_MAX - 1);
		phase_value[1] = 0;
		phase_value[2] = SMOKE_MAX;
		phase_value[3] = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd5000;
		phase_value[4] = $urandom_range(1, SMOKE_MAX - 1);
		for (int p = 0; p < PHASES; p++) begin
			set_threshold(phase_value[p]);
			for (int i = 0; i < PHASE_TICKS; i++) begin
				tx_quiet = (i >= 60 && i < 100);
				rx_quiet = tx_quiet;
				if (p == 1 && i == 60)
					hold_off_pending = 1'b1;
				send_tick(random_tick());
			end
			tx_quiet = 1'b0;
			rx_quiet = 1'b0;
			drain();
		end

		$display("covered %0d ticks and %0d status results over %0d threshold settings",
			ticks_sent, board.checked, settings_used);
		$display("access alarm tripped %0d times, fire alarm %0d times; one %0d-cycle hold-off",
			board.access_trips, board.fire_trips, HOLD_OFF_CYCLES);
		if (board.errors == 0 && board.pending() == 0)
			$display("intrusion_and_smoke_alarm_core test passed");
		else
			$display("intrusion_and_smoke_alarm_core test failed");
		$finish;
	end

endmodule
